/* design/hlcd_pkg.sv */
// shared types and constants for the header/length/checksum deframer
package hlcd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef logic [BYTE_W-1:0] byte_t;

	// register indexes (byte address is 4 * index)
	typedef enum logic [1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_SYNC_THIRD  = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	// frame status codes
	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_GOOD     = 2'd1,
		ST_CKSUM    = 2'd2,
		ST_BAD_LEN  = 2'd3
	} frame_status_t;

	localparam byte_t SYNC_FIRST_RST  = 8'hA5;
	localparam byte_t SYNC_SECOND_RST = 8'h5A;
	localparam byte_t SYNC_THIRD_RST  = 8'h22;

	// header length plus length byte
	localparam byte_t LEN_EXTRA = 8'd4;
	localparam byte_t MIN_TOTAL = 8'd5;

	// result word carried by the output register and skid stage
	typedef struct packed {
		byte_t         frame_byte;
		byte_t         body_offset;
		logic          end_of_frame;
		frame_status_t frame_status;
	} result_t;

endpackage

/* design/header_length_checksum_deframer.sv */
// sync header hunt, length check and additive checksum over a received byte stream
//
// One received word is accepted per cycle (in_valid and in_ready both high). Each word
// is handled in the cycle it is accepted, against the hunt and frame state registers,
// and its result, if any, is written at the accepting edge to the output register and
// offered on the next cycle, or, while that register is full and stalled, to the skid
// stage. The skid stage behind the output register keeps in_ready high while one result waits to be
// taken; in_ready drops only when both the output register and the skid stage are full.
// Header words give no result. Every word after the header gives one result with its
// offset after the header; the length word L makes the frame L+4 words long, and L of 0
// or 252 to 255 aborts the frame with bad length status. The last word closes the frame
// with good or checksum error status, the checksum being the 8-bit sum of all earlier
// frame words, header included. The three sync registers sit at byte addresses 0, 4, 8.
module header_length_checksum_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hlcd_pkg::ADDR_W-1:0]  paddr,
	input  logic [hlcd_pkg::DATA_W-1:0]  pwdata,
	output logic [hlcd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hlcd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hlcd_pkg::BYTE_W-1:0]  frame_byte,
	output logic [hlcd_pkg::BYTE_W-1:0]  body_offset,
	output logic                         end_of_frame,
	output logic [1:0]                   frame_status
);
	import hlcd_pkg::*;

	byte_t sync_first_q, sync_second_q, sync_third_q;

	logic       inside_frame_q;
	logic [1:0] sync_matched_q;
	byte_t      bytes_taken_q;
	byte_t      frame_total_q;
	byte_t      running_sum_q;

	logic       out_v_q, skid_v_q;
	result_t    out_q, skid_q;

	reg_idx_t   widx;
	logic       wr_en;

	logic       take;
	logic       push;
	result_t    res;
	byte_t      expected;
	logic [1:0] hunt_idx;

	logic       inside_d;
	logic [1:0] matched_d;
	byte_t      taken_d;
	byte_t      total_d;
	byte_t      sum_d;
	byte_t      len_total;
	logic [8:0] last_pos;

	// config port
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		case (widx)
			REG_SYNC_FIRST:  prdata = {{(DATA_W-BYTE_W){1'b0}}, sync_first_q};
			REG_SYNC_SECOND: prdata = {{(DATA_W-BYTE_W){1'b0}}, sync_second_q};
			REG_SYNC_THIRD:  prdata = {{(DATA_W-BYTE_W){1'b0}}, sync_third_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			sync_third_q  <= SYNC_THIRD_RST;
		end else if (wr_en) begin
			case (widx)
				REG_SYNC_FIRST:  sync_first_q  <= pwdata[BYTE_W-1:0];
				REG_SYNC_SECOND: sync_second_q <= pwdata[BYTE_W-1:0];
				REG_SYNC_THIRD:  sync_third_q  <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// per-word logic
	assign in_ready  = !skid_v_q;
	assign take      = in_valid && in_ready;
	assign hunt_idx  = (sync_matched_q == 2'd3) ? 2'd0 : sync_matched_q;
	assign len_total = rx_byte + LEN_EXTRA;
	assign last_pos  = {1'b0, bytes_taken_q} + {1'b0, LEN_EXTRA};

	always_comb begin
		case (hunt_idx)
			2'd0:    expected = sync_first_q;
			2'd1:    expected = sync_second_q;
			default: expected = sync_third_q;
		endcase
	end

	always_comb begin
		inside_d = inside_frame_q;
		matched_d = sync_matched_q;
		taken_d = bytes_taken_q;
		total_d = frame_total_q;
		sum_d = running_sum_q;
		push = 1'b0;
		res.frame_byte   = rx_byte;
		res.body_offset  = bytes_taken_q;
		res.end_of_frame = 1'b0;
		res.frame_status = ST_BUSY;
		if (!inside_frame_q) begin
			if (rx_byte == expected) begin
				sum_d = (hunt_idx == 2'd0) ? rx_byte : running_sum_q + rx_byte;
				if (hunt_idx == 2'd2) begin
					inside_d  = 1'b1;
					matched_d = 2'd0;
					taken_d   = '0;
					total_d   = '0;
				end else begin
					matched_d = hunt_idx + 2'd1;
				end
			end else begin
				matched_d = 2'd0;
			end
		end else begin
			push = 1'b1;
			if (bytes_taken_q == '0) begin
				if (rx_byte == '0 || len_total < MIN_TOTAL) begin
					inside_d  = 1'b0;
					matched_d = 2'd0;
					taken_d   = '0;
					total_d   = '0;
					res.end_of_frame = 1'b1;
					res.frame_status = ST_BAD_LEN;
				end else begin
					total_d = len_total;
					sum_d   = running_sum_q + rx_byte;
					taken_d = 8'd1;
				end
			end else if (last_pos == {1'b0, frame_total_q}) begin
				inside_d  = 1'b0;
				matched_d = 2'd0;
				taken_d   = '0;
				total_d   = '0;
				res.end_of_frame = 1'b1;
				res.frame_status = (running_sum_q == rx_byte) ? ST_GOOD : ST_CKSUM;
			end else begin
				sum_d   = running_sum_q + rx_byte;
				taken_d = bytes_taken_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_frame_q <= 1'b0;
			sync_matched_q <= 2'd0;
			bytes_taken_q  <= '0;
			frame_total_q  <= '0;
			running_sum_q  <= '0;
		end else if (take) begin
			inside_frame_q <= inside_d;
			sync_matched_q <= matched_d;
			bytes_taken_q  <= taken_d;
			frame_total_q  <= total_d;
			running_sum_q  <= sum_d;
		end
	end

	// output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= take && push;
			end else begin
				out_v_q <= take && push;
			end
		end else if (take && push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (take && push) begin
					skid_q <= res;
				end
			end else if (take && push) begin
				out_q <= res;
			end
		end else if (take && push) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_v_q;
	assign frame_byte   = out_q.frame_byte;
	assign body_offset  = out_q.body_offset;
	assign end_of_frame = out_q.end_of_frame;
	assign frame_status = out_q.frame_status;

endmodule

/* tb/sv/tb_header_length_checksum_deframer.sv */
// testbench for the header/length/checksum deframer: directed table, random frames, self-checking
module tb_header_length_checksum_deframer;
	import hlcd_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PHASE_WORDS    = 210;
	localparam result_t     NO_RESULT      = '0;

	typedef struct packed {
		byte_t   word;
		logic    shown;
		logic    gives;
		result_t want;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic [7:0]  body_offset;
	logic        end_of_frame;
	logic [1:0]  frame_status;

	// expected deframer state
	byte_t       sync_reg [3] = '{SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST};
	logic        in_frame = 1'b0;
	logic [1:0]  match_cnt = '0;
	byte_t       taken = '0;
	byte_t       total = '0;
	byte_t       frame_sum = '0;

	result_t     awaited_results [$];
	int unsigned mismatch_count = 0;
	int unsigned words_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req = 1'b0;

	vector_t directed [0:21] = '{
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'h22, 1'b0, 1'b0, NO_RESULT},
		'{8'hA5, 1'b1, 1'b0, NO_RESULT},
		'{8'h5A, 1'b1, 1'b0, NO_RESULT},
		'{8'h22, 1'b1, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1, '{8'h00, 8'd0, 1'b1, ST_BAD_LEN}},
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'h22, 1'b0, 1'b0, NO_RESULT},
		'{8'hFC, 1'b1, 1'b1, '{8'hFC, 8'd0, 1'b1, ST_BAD_LEN}},
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'h22, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b1, 1'b1, '{8'h01, 8'd0, 1'b0, ST_BUSY}},
		'{8'h22, 1'b1, 1'b1, '{8'h22, 8'd1, 1'b1, ST_GOOD}},
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'h22, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b1, 1'b1, '{8'h01, 8'd0, 1'b0, ST_BUSY}},
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 8'd1, 1'b1, ST_CKSUM}}
	};

	header_length_checksum_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.body_offset  (body_offset),
		.end_of_frame (end_of_frame),
		.frame_status (frame_status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic track_deframer(input byte_t b, output logic gives, output result_t r);
		logic [1:0] slot;
		byte_t      len_total;
		gives = 1'b0;
		r = NO_RESULT;
		if (!in_frame) begin
			slot = (match_cnt == 2'd3) ? 2'd0 : match_cnt;
			if (b == sync_reg[slot]) begin
				frame_sum = (slot == 2'd0) ? b : byte_t'(frame_sum + b);
				if (slot == 2'd2) begin
					in_frame = 1'b1;
					match_cnt = '0;
					taken = '0;
					total = '0;
				end else begin
					match_cnt = slot + 2'd1;
				end
			end else begin
				match_cnt = '0;
			end
		end else begin
			gives = 1'b1;
			r.frame_byte = b;
			r.body_offset = taken;
			len_total = b + LEN_EXTRA;
			if (taken == 8'd0 && (b == 8'd0 || len_total < MIN_TOTAL)) begin
				r.end_of_frame = 1'b1;
				r.frame_status = ST_BAD_LEN;
				in_frame = 1'b0;
				match_cnt = '0;
				taken = '0;
				total = '0;
			end else if (taken != 8'd0 && ({1'b0, taken} + 9'd4) == {1'b0, total}) begin
				r.end_of_frame = 1'b1;
				r.frame_status = (frame_sum == b) ? ST_GOOD : ST_CKSUM;
				in_frame = 1'b0;
				match_cnt = '0;
				taken = '0;
				total = '0;
			end else begin
				r.end_of_frame = 1'b0;
				r.frame_status = ST_BUSY;
				if (taken == 8'd0)
					total = len_total;
				frame_sum = frame_sum + b;
				taken = taken + 8'd1;
			end
		end
	endtask

	task automatic send_word(input vector_t v);
		logic    gives;
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= v.word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_deframer(v.word, gives, r);
		if (v.shown) begin
			if (v.gives)
				awaited_results.push_back(v.want);
		end else if (gives) begin
			awaited_results.push_back(r);
		end
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input byte_t b);
		send_word('{b, 1'b0, 1'b0, NO_RESULT});
	endtask

	task automatic send_head(input byte_t len);
		send_byte(sync_reg[0]);
		send_byte(sync_reg[1]);
		send_byte(sync_reg[2]);
		send_byte(len);
	endtask

	task automatic send_body(input int unsigned n_data, input bit good_sum);
		repeat (n_data)
			send_byte(byte_t'($urandom_range(255)));
		send_byte(good_sum ? frame_sum : byte_t'($urandom_range(255)));
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input byte_t v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx != REG_UNUSED)
			sync_reg[idx] = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read_check(input reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {24'h0, sync_reg[idx]}) begin
			$display("%0t: register %0d read expected %h, got %h", $time, idx,
				{24'h0, sync_reg[idx]}, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// the unused index is written too; the read back shows it changed nothing
	task automatic write_sync(input byte_t a, input byte_t b, input byte_t c);
		apb_write(REG_SYNC_FIRST, a);
		apb_write(REG_SYNC_SECOND, b);
		apb_write(REG_SYNC_THIRD, c);
		apb_write(REG_UNUSED, byte_t'($urandom_range(255)));
		apb_read_check(REG_SYNC_FIRST);
		apb_read_check(REG_SYNC_SECOND);
		apb_read_check(REG_SYNC_THIRD);
	endtask

	task automatic run_random(input int unsigned n_words);
		int unsigned goal;
		int unsigned pick;
		byte_t       len;
		goal = words_sent + n_words;
		while (words_sent < goal) begin
			repeat ($urandom_range(3)) begin
				if ($urandom_range(9) < 6) begin
					send_byte(byte_t'($urandom_range(255)));
				end else begin
					send_byte(sync_reg[0]);
					if ($urandom_range(1))
						send_byte(sync_reg[1]);
					send_byte(byte_t'($urandom_range(255)));
				end
			end
			pick = $urandom_range(99);
			if (pick < 2)
				len = 8'd0;
			else if (pick < 6)
				len = byte_t'($urandom_range(255, 252));
			else if (pick < 9)
				len = byte_t'($urandom_range(251, 100));
			else
				len = byte_t'($urandom_range(12, 1));
			send_head(len);
			if (len != 8'd0 && len < 8'd252)
				send_body(len - 1, $urandom_range(9) < 7);
		end
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : take_result
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected word %h offset %h eof %b status %h", $time,
					frame_byte, body_offset, end_of_frame, frame_status);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("frame_byte", want.frame_byte, frame_byte);
				check_field("body_offset", want.body_offset, body_offset);
				check_field("end_of_frame", {7'd0, want.end_of_frame}, {7'd0, end_of_frame});
				check_field("frame_status", {6'd0, want.frame_status}, {6'd0, frame_status});
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_header_length_checksum_deframer: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		apb_read_check(REG_SYNC_FIRST);
		apb_read_check(REG_SYNC_SECOND);
		apb_read_check(REG_SYNC_THIRD);

		send_idle_pct = 12;
		recv_stall_pct = 12;
		foreach (directed[i])
			send_word(directed[i]);
		pause_until_drained();

		// receiver holds off while a long frame keeps coming
		write_sync(8'h00, 8'h00, 8'h00);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		send_head(8'd40);
		send_body(39, 1'b1);
		send_head(8'd251);
		send_body(250, 1'b1);
		run_random(PHASE_WORDS);
		pause_until_drained();

		write_sync(8'hFF, 8'hFF, 8'hFF);
		send_idle_pct = 88;
		recv_stall_pct = 0;
		run_random(PHASE_WORDS);

		// sync registers change with a frame open
		send_head(8'd3);
		send_byte(byte_t'($urandom_range(255)));
		pause_until_drained();
		write_sync(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
			byte_t'($urandom_range(255)));
		send_idle_pct = 0;
		recv_stall_pct = 88;
		send_body(1, 1'b1);
		run_random(PHASE_WORDS);
		pause_until_drained();

		write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST);
		send_idle_pct = 12;
		recv_stall_pct = 12;
		run_random(PHASE_WORDS);
		pause_until_drained();
		repeat (10)
			@(negedge clk);

		if (mismatch_count == 0)
			$display("tb_header_length_checksum_deframer: done, clean");
		else
			$display("tb_header_length_checksum_deframer: done, errors");
		$finish;
	end

endmodule
